### hdl/tkfe_pkg.sv
// ============================================================================
// Touch key front end: shared package
// Item types, configuration register codes, reset values and the command and
// status groups that join the controller to the datapath.
// ============================================================================
`default_nettype none

package tkfe_pkg;

    localparam int MAX_RECTS   = 16;
    localparam int RECT_IDX_W  = $clog2(MAX_RECTS);
    localparam int RECT_CNT_W  = $clog2(MAX_RECTS + 1);
    localparam int COUNT_W     = 5;
    localparam int SCAN_W      = (RECT_CNT_W > COUNT_W) ? RECT_CNT_W : COUNT_W;

    localparam logic [15:0] IDLE_CODE   = 16'hFFFF;
    localparam logic [31:0] DEBOUNCE_MS = 32'd10;

    // Serial divider: two quotient bits per cycle over a 32-bit dividend.
    localparam int DIV_W          = 32;
    localparam int DIV_BITS_STEP  = 2;
    localparam int DIV_STEPS      = DIV_W / DIV_BITS_STEP;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

    localparam logic [31:0] COEF_A_RST = 32'd5200;
    localparam logic [31:0] COEF_B_RST = 32'd513600;
    localparam logic [31:0] COEF_C_RST = 32'd4247661336;
    localparam logic [31:0] COEF_D_RST = 32'd4294598656;
    localparam logic [31:0] COEF_E_RST = 32'd2160;
    localparam logic [31:0] COEF_F_RST = 32'd687023640;
    localparam logic [31:0] COEF_K_RST = 32'd1972341;

    localparam logic CMD_TOUCH = 1'b0;
    localparam logic CMD_RECT  = 1'b1;

    typedef enum logic [2:0] {
        CFG_COEF_A = 3'd0,
        CFG_COEF_B = 3'd1,
        CFG_COEF_C = 3'd2,
        CFG_COEF_D = 3'd3,
        CFG_COEF_E = 3'd4,
        CFG_COEF_F = 3'd5,
        CFG_COEF_K = 3'd6,
        CFG_SILENT = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic         cmd;
        logic         pen_down;
        logic [11:0]  raw_x;
        logic [11:0]  raw_y;
        logic [31:0]  now_ms;
        logic [4:0]   rect_count;
        logic [3:0]   rect_index;
        logic [15:0]  rect_left;
        logic [15:0]  rect_right;
        logic [15:0]  rect_top;
        logic [15:0]  rect_bottom;
    } in_item_t;

    typedef struct packed {
        logic         key_valid;
        logic [15:0]  key_code;
        logic         redraw_valid;
        logic [15:0]  redraw_key;
        logic         redraw_pressed;
        logic         beep;
    } out_item_t;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] right;
        logic [15:0] top;
        logic [15:0] bottom;
    } rect_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD_X,
        ST_PROD_Y,
        ST_DIV_START,
        ST_DIV_RUN,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic prod_x;
        logic prod_y;
        logic div_start;
        logic div_save;
        logic axis;
        logic scan_init;
        logic scan_step;
        logic press_fin;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic need_map;
        logic div_done;
        logic scan_done;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

### hdl/tkfe_if.sv
// ============================================================================
// Touch key front end: item channels
// Valid/ready channels for touch and rectangle items in and results out.
// ============================================================================
`default_nettype none

interface tkfe_in_if;
    logic                 valid;
    logic                 ready;
    tkfe_pkg::in_item_t   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface tkfe_out_if;
    logic                 valid;
    logic                 ready;
    tkfe_pkg::out_item_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### hdl/tkfe_div.sv
// ============================================================================
// Touch key front end: serial divider
// Unsigned restoring division, two quotient bits per cycle. A zero divisor
// yields an all-ones quotient because every trial subtraction succeeds.
// ============================================================================
`default_nettype none

module tkfe_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [tkfe_pkg::DIV_W-1:0]    dividend,
    input  wire logic [tkfe_pkg::DIV_W-1:0]    divisor,
    output logic                               done,
    output logic [tkfe_pkg::DIV_W-1:0]         quotient
);

    logic [tkfe_pkg::DIV_W-1:0]     rem_reg;
    logic [tkfe_pkg::DIV_W-1:0]     quo_reg;
    logic [tkfe_pkg::DIV_W-1:0]     rem_next;
    logic [tkfe_pkg::DIV_W-1:0]     quo_next;
    logic [tkfe_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    always_comb
    begin
        logic [tkfe_pkg::DIV_W:0] trial;
        rem_next = rem_reg;
        quo_next = quo_reg;
        for (int i = 0; i < tkfe_pkg::DIV_BITS_STEP; i++)
        begin
            trial    = {rem_next, quo_next[tkfe_pkg::DIV_W-1]};
            quo_next = {quo_next[tkfe_pkg::DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                trial       = trial - {1'b0, divisor};
                quo_next[0] = 1'b1;
            end
            rem_next = trial[tkfe_pkg::DIV_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == tkfe_pkg::DIV_CNT_W'(tkfe_pkg::DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### hdl/tkfe_dpath.sv
// ============================================================================
// Touch key front end: datapath
// Configuration registers, debounce state, affine mapping with a shared
// multiplier and serial divider, rectangle table scan and the output register.
// ============================================================================
`default_nettype none

module tkfe_dpath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [31:0]          cfg_wdata,
    input  wire tkfe_pkg::in_item_t   in_item,
    input  wire tkfe_pkg::dp_cmd_t    cmd,
    output tkfe_pkg::dp_status_t      status,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output tkfe_pkg::out_item_t       out_item
);

    // Configuration
    logic [31:0] coef_a_reg, coef_b_reg, coef_c_reg, coef_d_reg;
    logic [31:0] coef_e_reg, coef_f_reg, coef_k_reg;
    logic        silent_reg;

    // Touch state
    logic        pressed_reg;
    logic [31:0] deadline_reg;
    logic        awaiting_reg;
    logic [15:0] held_key_reg;

    // Item registers
    logic [11:0]                  raw_x_reg;
    logic [11:0]                  raw_y_reg;
    logic [tkfe_pkg::COUNT_W-1:0] count_reg;

    // Mapping
    logic [31:0] prod_reg;
    logic [31:0] acc_reg;
    logic [31:0] prod_next;
    logic [31:0] mul_coef;
    logic [31:0] mul_raw;
    logic [15:0] px_reg;
    logic [15:0] py_reg;
    logic        div_done;
    logic [31:0] div_quo;

    // Rectangle table, undefined until written
    tkfe_pkg::rect_t               rect_mem [tkfe_pkg::MAX_RECTS];
    tkfe_pkg::rect_t               rect_rd_reg;
    logic [tkfe_pkg::RECT_IDX_W-1:0] scan_addr;
    logic [tkfe_pkg::SCAN_W-1:0]   scan_cnt_reg;
    logic [tkfe_pkg::SCAN_W-1:0]   scan_limit;
    logic                          found_reg;
    logic [tkfe_pkg::RECT_IDX_W-1:0] hit_idx_reg;
    logic                          hit;
    logic [15:0]                   press_key;

    // Debounce decision for the item on the input
    logic        pressed_next;
    logic [31:0] deadline_next;

    tkfe_pkg::out_item_t res_reg;
    tkfe_pkg::out_item_t res_next;
    tkfe_pkg::out_item_t idle_res;
    tkfe_pkg::out_item_t out_reg;
    logic                out_valid_reg;

    always_comb
    begin
        idle_res                = '0;
        idle_res.key_code       = tkfe_pkg::IDLE_CODE;
        idle_res.redraw_key     = tkfe_pkg::IDLE_CODE;
    end

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg <= tkfe_pkg::COEF_A_RST;
            coef_b_reg <= tkfe_pkg::COEF_B_RST;
            coef_c_reg <= tkfe_pkg::COEF_C_RST;
            coef_d_reg <= tkfe_pkg::COEF_D_RST;
            coef_e_reg <= tkfe_pkg::COEF_E_RST;
            coef_f_reg <= tkfe_pkg::COEF_F_RST;
            coef_k_reg <= tkfe_pkg::COEF_K_RST;
            silent_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (tkfe_pkg::cfg_index_t'(cfg_index))
                tkfe_pkg::CFG_COEF_A: coef_a_reg <= cfg_wdata;
                tkfe_pkg::CFG_COEF_B: coef_b_reg <= cfg_wdata;
                tkfe_pkg::CFG_COEF_C: coef_c_reg <= cfg_wdata;
                tkfe_pkg::CFG_COEF_D: coef_d_reg <= cfg_wdata;
                tkfe_pkg::CFG_COEF_E: coef_e_reg <= cfg_wdata;
                tkfe_pkg::CFG_COEF_F: coef_f_reg <= cfg_wdata;
                tkfe_pkg::CFG_COEF_K: coef_k_reg <= cfg_wdata;
                tkfe_pkg::CFG_SILENT: silent_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- debounce
    always_comb
    begin
        if (in_item.pen_down)
        begin
            pressed_next  = pressed_reg | (deadline_reg <= in_item.now_ms);
            deadline_next = deadline_reg;
        end
        else
        begin
            pressed_next  = 1'b0;
            deadline_next = in_item.now_ms + tkfe_pkg::DEBOUNCE_MS;
        end
    end

    // ---------------------------------------------------------------- scan
    assign scan_limit = (tkfe_pkg::SCAN_W'(count_reg) > tkfe_pkg::SCAN_W'(tkfe_pkg::MAX_RECTS))
                        ? tkfe_pkg::SCAN_W'(tkfe_pkg::MAX_RECTS)
                        : tkfe_pkg::SCAN_W'(count_reg);
    // The table is read one entry ahead, so the registered entry always
    // matches the scan counter.
    assign scan_addr  = cmd.scan_init ? '0
                        : (cmd.scan_step ? scan_cnt_reg[tkfe_pkg::RECT_IDX_W-1:0] + 1'b1
                                         : scan_cnt_reg[tkfe_pkg::RECT_IDX_W-1:0]);
    assign hit        = (px_reg > rect_rd_reg.left) && (px_reg < rect_rd_reg.right)
                        && (py_reg > rect_rd_reg.top) && (py_reg < rect_rd_reg.bottom);
    assign press_key  = found_reg ? 16'(hit_idx_reg) : tkfe_pkg::IDLE_CODE;

    always_ff @(posedge clk)
    begin
        if (cmd.load && (in_item.cmd == tkfe_pkg::CMD_RECT)
            && (int'(in_item.rect_index) < tkfe_pkg::MAX_RECTS))
        begin
            rect_mem[tkfe_pkg::RECT_IDX_W'(in_item.rect_index)] <=
                {in_item.rect_left, in_item.rect_right, in_item.rect_top, in_item.rect_bottom};
        end
        rect_rd_reg <= rect_mem[scan_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg <= '0;
            found_reg    <= 1'b0;
        end
        else if (cmd.scan_init)
        begin
            scan_cnt_reg <= '0;
            found_reg    <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            scan_cnt_reg <= scan_cnt_reg + 1'b1;
            found_reg    <= hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step)
        begin
            hit_idx_reg <= scan_cnt_reg[tkfe_pkg::RECT_IDX_W-1:0];
        end
    end

    // ---------------------------------------------------------------- mapping
    // One multiplier serves both terms of both axes; only the low 32 bits are kept.
    always_comb
    begin
        if (cmd.prod_y)
        begin
            mul_coef = cmd.axis ? coef_e_reg : coef_b_reg;
            mul_raw  = {20'd0, raw_y_reg};
        end
        else
        begin
            mul_coef = cmd.axis ? coef_d_reg : coef_a_reg;
            mul_raw  = {20'd0, raw_x_reg};
        end
        prod_next = mul_coef * mul_raw;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            raw_x_reg <= in_item.raw_x;
            raw_y_reg <= in_item.raw_y;
            count_reg <= in_item.rect_count;
        end
        if (cmd.prod_x)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.prod_y)
        begin
            prod_reg <= prod_next;
            acc_reg  <= prod_reg + (cmd.axis ? coef_f_reg : coef_c_reg);
        end
        if (cmd.div_save)
        begin
            if (cmd.axis)
            begin
                py_reg <= div_quo[15:0];
            end
            else
            begin
                px_reg <= div_quo[15:0];
            end
        end
    end

    tkfe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (acc_reg + prod_reg),
        .divisor  (coef_k_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // ---------------------------------------------------------------- touch state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg  <= 1'b0;
            deadline_reg <= '0;
            awaiting_reg <= 1'b1;
            held_key_reg <= tkfe_pkg::IDLE_CODE;
        end
        else if (cmd.load && (in_item.cmd == tkfe_pkg::CMD_TOUCH))
        begin
            pressed_reg  <= pressed_next;
            deadline_reg <= deadline_next;
            if (!pressed_next && !awaiting_reg)
            begin
                held_key_reg <= tkfe_pkg::IDLE_CODE;
                awaiting_reg <= 1'b1;
            end
        end
        else if (cmd.press_fin)
        begin
            held_key_reg <= press_key;
            awaiting_reg <= 1'b0;
        end
    end

    // ---------------------------------------------------------------- result
    always_comb
    begin
        res_next = res_reg;
        if (cmd.load)
        begin
            res_next = idle_res;
            if ((in_item.cmd == tkfe_pkg::CMD_TOUCH) && !pressed_next && !awaiting_reg)
            begin
                res_next.key_valid    = 1'b1;
                res_next.key_code     = held_key_reg;
                res_next.redraw_valid = 1'b1;
                res_next.redraw_key   = held_key_reg;
            end
        end
        else if (cmd.press_fin)
        begin
            res_next                = idle_res;
            res_next.redraw_valid   = 1'b1;
            res_next.redraw_key     = press_key;
            res_next.redraw_pressed = 1'b1;
            res_next.beep           = (press_key != tkfe_pkg::IDLE_CODE) && !silent_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg <= res_reg;
        end
    end

    // ---------------------------------------------------------------- status
    always_comb
    begin
        status.need_map  = (in_item.cmd == tkfe_pkg::CMD_TOUCH) && pressed_next
                           && awaiting_reg;
        status.div_done  = div_done;
        status.scan_done = found_reg || (scan_cnt_reg >= scan_limit);
        status.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

`default_nettype wire

### hdl/tkfe_ctrl.sv
// ============================================================================
// Touch key front end: controller
// Sequences one item at a time through mapping of both axes, division,
// rectangle scan (first press only) and hand-over to the output register.
// ============================================================================
`default_nettype none

module tkfe_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire tkfe_pkg::dp_status_t  status,
    output tkfe_pkg::dp_cmd_t          cmd
);

    tkfe_pkg::state_t state_reg;
    tkfe_pkg::state_t state_next;
    logic             axis_reg;
    logic             axis_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tkfe_pkg::ST_IDLE;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        case (state_reg)
            tkfe_pkg::ST_IDLE:
            begin
                axis_next = 1'b0;
                if (in_valid)
                begin
                    state_next = status.need_map ? tkfe_pkg::ST_PROD_X : tkfe_pkg::ST_DONE;
                end
            end
            tkfe_pkg::ST_PROD_X:    state_next = tkfe_pkg::ST_PROD_Y;
            tkfe_pkg::ST_PROD_Y:    state_next = tkfe_pkg::ST_DIV_START;
            tkfe_pkg::ST_DIV_START: state_next = tkfe_pkg::ST_DIV_RUN;
            tkfe_pkg::ST_DIV_RUN:
            begin
                if (status.div_done)
                begin
                    if (axis_reg)
                    begin
                        state_next = tkfe_pkg::ST_SCAN;
                    end
                    else
                    begin
                        axis_next  = 1'b1;
                        state_next = tkfe_pkg::ST_PROD_X;
                    end
                end
            end
            tkfe_pkg::ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = tkfe_pkg::ST_DONE;
                end
            end
            tkfe_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = tkfe_pkg::ST_IDLE;
                end
            end
            default: state_next = tkfe_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        cmd.axis = axis_reg;
        in_ready = 1'b0;
        case (state_reg)
            tkfe_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            tkfe_pkg::ST_PROD_X:    cmd.prod_x    = 1'b1;
            tkfe_pkg::ST_PROD_Y:    cmd.prod_y    = 1'b1;
            tkfe_pkg::ST_DIV_START: cmd.div_start = 1'b1;
            tkfe_pkg::ST_DIV_RUN:
            begin
                cmd.div_save  = status.div_done;
                cmd.scan_init = status.div_done && axis_reg;
            end
            tkfe_pkg::ST_SCAN:
            begin
                cmd.scan_step = !status.scan_done;
                cmd.press_fin = status.scan_done;
            end
            tkfe_pkg::ST_DONE:      cmd.out_load  = status.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

### hdl/touch_key_front_end_core.sv
// ============================================================================
// Touch key front end core
// Debounced touch sampling, affine pixel mapping and rectangle hit test.
// ============================================================================
// Items arrive on in_ch: cmd 1 writes one rectangle entry, cmd 0 is a touch
// sample. Every item yields exactly one result item on out_ch. Coefficients
// and the silent flag are written through cfg_wr_en/cfg_index/cfg_wdata, by
// the user only while the block is idle; the block itself does not enforce it.
// A rectangle write, a held or lifted pen and a release skip the mapping: the
// result is registered, moved to the output register once that is free, and
// the next item is taken after that. The first accepted press maps both axes,
// each through the PROD_X, PROD_Y and DIV_START multiply/add states and a
// divider that yields two quotient bits per cycle, then scans up to 16
// rectangles one per cycle until a hit, and its result goes on to the output
// register by way of the result register in the same manner.
// One item is in work at a time; the next is taken once the result has moved
// to the output register, so a stalled receiver holds only that register
// while the next item is processed, and a further result waits until the
// register is free.
// Reset restores the default calibration, clears the press state and makes
// no result valid. Rectangle entries are not cleared and must be written
// before they are tested.
// ============================================================================
`default_nettype none

module touch_key_front_end_core (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata,
    tkfe_in_if.sink      in_ch,
    tkfe_out_if.source   out_ch
);

    tkfe_pkg::dp_cmd_t    cmd;
    tkfe_pkg::dp_status_t status;

    tkfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    tkfe_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_item   (in_ch.payload),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_item  (out_ch.payload)
    );

endmodule

`default_nettype wire

### bench/touch_key_front_end_core_test.sv
// ============================================================================
// Touch key front end core: self-checking testbench
// Drives touch samples and rectangle writes through the item channel,
// predicts every result from its own model of debounce, pixel mapping and
// hit test, and checks each result item field by field. The run walks
// several calibration settings and three idling regimes, with one long
// receiver hold-off so that the block fills up and stalls its input.
// ============================================================================

module touch_key_front_end_core_test;

    localparam tkfe_pkg::out_item_t NO_EVENT =
        {1'b0, tkfe_pkg::IDLE_CODE, 1'b0, tkfe_pkg::IDLE_CODE, 1'b0, 1'b0};
    localparam tkfe_pkg::out_item_t PRESS_IDLE =
        {1'b0, tkfe_pkg::IDLE_CODE, 1'b1, tkfe_pkg::IDLE_CODE, 1'b1, 1'b0};
    localparam tkfe_pkg::out_item_t RELEASE_IDLE =
        {1'b1, tkfe_pkg::IDLE_CODE, 1'b1, tkfe_pkg::IDLE_CODE, 1'b0, 1'b0};

    typedef struct {
        tkfe_pkg::in_item_t  item;
        bit                  typed;
        tkfe_pkg::out_item_t want;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    tkfe_pkg::cfg_index_t cfg_index;
    logic [31:0]          cfg_wdata;

    tkfe_in_if  in_ch ();
    tkfe_out_if out_ch ();

    touch_key_front_end_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always #6 clk = ~clk;

    // Shadow calibration and touch state.
    logic [31:0] cal_a = tkfe_pkg::COEF_A_RST;
    logic [31:0] cal_b = tkfe_pkg::COEF_B_RST;
    logic [31:0] cal_c = tkfe_pkg::COEF_C_RST;
    logic [31:0] cal_d = tkfe_pkg::COEF_D_RST;
    logic [31:0] cal_e = tkfe_pkg::COEF_E_RST;
    logic [31:0] cal_f = tkfe_pkg::COEF_F_RST;
    logic [31:0] cal_k = tkfe_pkg::COEF_K_RST;
    logic        quiet = 1'b0;

    logic        down_ok       = 1'b0;
    logic [31:0] lift_deadline = 32'd0;
    logic        armed         = 1'b1;
    logic [15:0] key_held      = tkfe_pkg::IDLE_CODE;
    tkfe_pkg::rect_t shadow_rects [tkfe_pkg::MAX_RECTS];

    tkfe_pkg::out_item_t results_due [$];
    stim_row_t           directed_rows [$];
    logic [23:0]         target_pool [$];

    int          send_idle_pct = 11;
    int          recv_idle_pct = 47;
    int          hold_left     = 0;
    int          mismatches    = 0;
    int          items_sent    = 0;
    int          settings_used = 0;
    int          presses       = 0;
    int          key_hits      = 0;
    int          releases      = 0;
    logic        finger        = 1'b0;
    logic [31:0] clock_ms      = 32'd0;

    task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    function automatic logic [15:0] map_axis(logic [31:0] wx, logic [31:0] wy,
                                             logic [31:0] off, logic [11:0] rx,
                                             logic [11:0] ry);
        logic [31:0] sum;
        logic [31:0] quo;
        sum = wx * 32'(rx) + wy * 32'(ry) + off;
        quo = (cal_k == 32'd0) ? 32'hFFFF_FFFF : sum / cal_k;
        return quo[15:0];
    endfunction

    function automatic logic [15:0] find_key(logic [11:0] rx, logic [11:0] ry,
                                             logic [4:0] count);
        logic [15:0] px;
        logic [15:0] py;
        int          n;
        px = map_axis(cal_a, cal_b, cal_c, rx, ry);
        py = map_axis(cal_d, cal_e, cal_f, rx, ry);
        n = (count > tkfe_pkg::MAX_RECTS) ? tkfe_pkg::MAX_RECTS : int'(count);
        for (int i = 0; i < n; i++)
        begin
            if (px > shadow_rects[i].left && px < shadow_rects[i].right &&
                py > shadow_rects[i].top && py < shadow_rects[i].bottom)
                return 16'(i);
        end
        return tkfe_pkg::IDLE_CODE;
    endfunction

    function automatic tkfe_pkg::out_item_t predict_result(tkfe_pkg::in_item_t it);
        tkfe_pkg::out_item_t r;
        r = NO_EVENT;
        if (it.cmd == tkfe_pkg::CMD_RECT)
        begin
            shadow_rects[it.rect_index] =
                {it.rect_left, it.rect_right, it.rect_top, it.rect_bottom};
        end
        else
        begin
            if (it.pen_down)
            begin
                if (lift_deadline <= it.now_ms)
                    down_ok = 1'b1;
            end
            else
            begin
                down_ok = 1'b0;
                lift_deadline = it.now_ms + tkfe_pkg::DEBOUNCE_MS;
            end
            if (down_ok)
            begin
                if (armed)
                begin
                    key_held = find_key(it.raw_x, it.raw_y, it.rect_count);
                    armed = 1'b0;
                    r.redraw_valid   = 1'b1;
                    r.redraw_key     = key_held;
                    r.redraw_pressed = 1'b1;
                    r.beep = (key_held != tkfe_pkg::IDLE_CODE) && !quiet;
                    presses++;
                    if (key_held != tkfe_pkg::IDLE_CODE)
                        key_hits++;
                end
            end
            else if (!armed)
            begin
                r.redraw_valid = 1'b1;
                r.redraw_key   = key_held;
                r.key_valid    = 1'b1;
                r.key_code     = key_held;
                key_held = tkfe_pkg::IDLE_CODE;
                armed = 1'b1;
                releases++;
            end
        end
        return r;
    endfunction

    function automatic void touch_row(logic pen, logic [11:0] rx, logic [11:0] ry,
                                      logic [31:0] now, logic [4:0] count,
                                      bit typed, tkfe_pkg::out_item_t want);
        stim_row_t row;
        row.item            = '0;
        row.item.cmd        = tkfe_pkg::CMD_TOUCH;
        row.item.pen_down   = pen;
        row.item.raw_x      = rx;
        row.item.raw_y      = ry;
        row.item.now_ms     = now;
        row.item.rect_count = count;
        row.typed           = typed;
        row.want            = want;
        directed_rows.push_back(row);
    endfunction

    function automatic void rect_row(logic [3:0] idx, logic [15:0] l, logic [15:0] r,
                                     logic [15:0] t, logic [15:0] b);
        stim_row_t row;
        row.item             = '0;
        row.item.cmd         = tkfe_pkg::CMD_RECT;
        row.item.rect_index  = idx;
        row.item.rect_left   = l;
        row.item.rect_right  = r;
        row.item.rect_top    = t;
        row.item.rect_bottom = b;
        row.typed            = 1'b1;
        row.want             = NO_EVENT;
        directed_rows.push_back(row);
    endfunction

    // Starts and ends at a falling edge; the item is predicted once accepted.
    task automatic send_item(tkfe_pkg::in_item_t it, bit typed, tkfe_pkg::out_item_t want);
        tkfe_pkg::out_item_t guess;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid   = 1'b1;
        in_ch.payload = it;
        do
            @(posedge clk);
        while (!in_ch.ready);
        guess = predict_result(it);
        results_due.push_back(typed ? want : guess);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (results_due.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(tkfe_pkg::cfg_index_t idx, logic [31:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        case (idx)
            tkfe_pkg::CFG_COEF_A: cal_a = val;
            tkfe_pkg::CFG_COEF_B: cal_b = val;
            tkfe_pkg::CFG_COEF_C: cal_c = val;
            tkfe_pkg::CFG_COEF_D: cal_d = val;
            tkfe_pkg::CFG_COEF_E: cal_e = val;
            tkfe_pkg::CFG_COEF_F: cal_f = val;
            tkfe_pkg::CFG_COEF_K: cal_k = val;
            tkfe_pkg::CFG_SILENT: quiet = val[0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                 logic [31:0] d, logic [31:0] e, logic [31:0] f,
                                 logic [31:0] k, logic [31:0] quiet_word);
        wait_drained();
        write_reg(tkfe_pkg::CFG_COEF_A, a);
        write_reg(tkfe_pkg::CFG_COEF_B, b);
        write_reg(tkfe_pkg::CFG_COEF_C, c);
        write_reg(tkfe_pkg::CFG_COEF_D, d);
        write_reg(tkfe_pkg::CFG_COEF_E, e);
        write_reg(tkfe_pkg::CFG_COEF_F, f);
        write_reg(tkfe_pkg::CFG_COEF_K, k);
        write_reg(tkfe_pkg::CFG_SILENT, quiet_word);
        target_pool.delete();
        settings_used++;
    endtask

    task automatic gen_item(output tkfe_pkg::in_item_t it);
        int          roll;
        int          room_lo;
        int          room_hi;
        logic [11:0] rx;
        logic [11:0] ry;
        logic [15:0] px;
        logic [15:0] py;
        it = tkfe_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
        roll = $urandom_range(0, 99);
        if (roll < 10)
        begin
            it.cmd = tkfe_pkg::CMD_RECT;
            // Most entries are placed around a raw point that later presses reuse,
            // so that hits land on many different entries.
            if ($urandom_range(0, 99) < 60)
            begin
                rx = 12'($urandom);
                ry = 12'($urandom);
                px = map_axis(cal_a, cal_b, cal_c, rx, ry);
                py = map_axis(cal_d, cal_e, cal_f, rx, ry);
                if (px != 16'd0 && px != 16'hFFFF && py != 16'd0 && py != 16'hFFFF)
                begin
                    room_lo = (px < 300) ? int'(px) : 300;
                    room_hi = (65535 - int'(px) < 300) ? 65535 - int'(px) : 300;
                    it.rect_left  = 16'(px - $urandom_range(1, room_lo));
                    it.rect_right = 16'(px + $urandom_range(1, room_hi));
                    room_lo = (py < 300) ? int'(py) : 300;
                    room_hi = (65535 - int'(py) < 300) ? 65535 - int'(py) : 300;
                    it.rect_top    = 16'(py - $urandom_range(1, room_lo));
                    it.rect_bottom = 16'(py + $urandom_range(1, room_hi));
                    target_pool.push_back({rx, ry});
                    if (target_pool.size() > 6)
                        void'(target_pool.pop_front());
                end
            end
        end
        else
        begin
            it.cmd = tkfe_pkg::CMD_TOUCH;
            if ($urandom_range(0, 99) < 15)
                finger = ~finger;
            it.pen_down = ($urandom_range(0, 99) < 8) ? ~finger : finger;
            roll = $urandom_range(0, 99);
            if (roll < 70)
                clock_ms += $urandom_range(0, 6);
            else if (roll < 95)
                clock_ms += $urandom_range(7, 40);
            else if (roll < 98)
                clock_ms += $urandom_range(0, 100000);
            else
                clock_ms = $urandom;
            it.now_ms = clock_ms;
            roll = $urandom_range(0, 99);
            if (roll < 40 && target_pool.size() != 0)
                {it.raw_x, it.raw_y} = target_pool[$urandom_range(0, target_pool.size() - 1)];
            else if (roll < 46)
            begin
                it.raw_x = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
                it.raw_y = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            end
            roll = $urandom_range(0, 99);
            if (roll < 5)
                it.rect_count = 5'd0;
            else if (roll < 15)
                it.rect_count = 5'($urandom_range(17, 31));
            else
                it.rect_count = 5'($urandom_range(1, 16));
        end
    endtask

    task automatic run_phase(int n_items);
        tkfe_pkg::in_item_t it;
        repeat (n_items)
        begin
            gen_item(it);
            send_item(it, 1'b0, NO_EVENT);
        end
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested.
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ch.ready = 1'b0;
                hold_left--;
            end
            else
                out_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        tkfe_pkg::out_item_t got;
        tkfe_pkg::out_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.payload;
            if (results_due.size() == 0)
                note_mismatch("result with nothing expected", 32'(got.key_code),
                              32'(tkfe_pkg::IDLE_CODE));
            else
            begin
                want = results_due.pop_front();
                if (got.key_valid !== want.key_valid)
                    note_mismatch("key_valid", 32'(got.key_valid), 32'(want.key_valid));
                if (got.key_code !== want.key_code)
                    note_mismatch("key_code", 32'(got.key_code), 32'(want.key_code));
                if (got.redraw_valid !== want.redraw_valid)
                    note_mismatch("redraw_valid", 32'(got.redraw_valid),
                                  32'(want.redraw_valid));
                if (got.redraw_key !== want.redraw_key)
                    note_mismatch("redraw_key", 32'(got.redraw_key), 32'(want.redraw_key));
                if (got.redraw_pressed !== want.redraw_pressed)
                    note_mismatch("redraw_pressed", 32'(got.redraw_pressed),
                                  32'(want.redraw_pressed));
                if (got.beep !== want.beep)
                    note_mismatch("beep", 32'(got.beep), 32'(want.beep));
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int                  waited;
        tkfe_pkg::out_item_t lost;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = tkfe_pkg::CFG_COEF_A;
        cfg_wdata     = '0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset state: the deadline starts at zero, so a press at time zero counts.
        touch_row(1'b1, 12'h000, 12'h000, 32'd0, 5'd0, 1'b1, PRESS_IDLE);
        touch_row(1'b1, 12'hFFF, 12'hFFF, 32'd1, 5'd0, 1'b1, NO_EVENT);
        touch_row(1'b0, 12'h000, 12'h000, 32'd2, 5'd0, 1'b1, RELEASE_IDLE);
        // Bounce inside the debounce window, then a press exactly at the deadline.
        touch_row(1'b1, 12'h800, 12'h800, 32'd5, 5'd0, 1'b1, NO_EVENT);
        touch_row(1'b1, 12'h800, 12'h800, 32'd11, 5'd0, 1'b1, NO_EVENT);
        touch_row(1'b1, 12'h800, 12'h800, 32'd12, 5'd0, 1'b1, PRESS_IDLE);
        touch_row(1'b0, 12'h800, 12'h800, 32'd20, 5'd0, 1'b1, RELEASE_IDLE);
        rect_row(4'd0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
        for (int e = 1; e < 15; e++)
            rect_row(4'(e), 16'(150 * e), 16'(150 * e + 400), 16'h0000, 16'hFFFF);
        rect_row(4'd15, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
        touch_row(1'b1, 12'hFFF, 12'hFFF, 32'd30, 5'd16, 1'b0, NO_EVENT);
        touch_row(1'b0, 12'hFFF, 12'hFFF, 32'd31, 5'd16, 1'b0, NO_EVENT);
        // The deadline wraps past zero, so the press just below the wrap counts.
        touch_row(1'b0, 12'h000, 12'h000, 32'hFFFF_FFF8, 5'd0, 1'b1, NO_EVENT);
        touch_row(1'b1, 12'h000, 12'h000, 32'hFFFF_FFFC, 5'd31, 1'b0, NO_EVENT);
        touch_row(1'b0, 12'h000, 12'h000, 32'hFFFF_FFFD, 5'd31, 1'b0, NO_EVENT);
        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        clock_ms = 32'hFFFF_FFFD;

        apply_setting(tkfe_pkg::COEF_A_RST, tkfe_pkg::COEF_B_RST, tkfe_pkg::COEF_C_RST,
                      tkfe_pkg::COEF_D_RST, tkfe_pkg::COEF_E_RST, tkfe_pkg::COEF_F_RST,
                      tkfe_pkg::COEF_K_RST, 32'd0);
        hold_left = 300;
        run_phase(265);
        apply_setting($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom_range(1, 65535), $urandom | 32'd1);
        run_phase(265);

        send_idle_pct = 47;
        recv_idle_pct = 11;
        apply_setting('1, '1, '1, '1, '1, '1, '1, 32'd0);
        run_phase(265);
        apply_setting('0, '0, '0, '0, '0, '0, '0, 32'd0);
        run_phase(265);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_setting($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      32'd1, 32'd1);
        run_phase(265);
        apply_setting($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom >> $urandom_range(0, 31), $urandom & 32'hFFFF_FFFE);
        run_phase(265);

        in_ch.valid = 1'b0;
        for (waited = 0; waited < 20000 && results_due.size() != 0; waited++)
            @(posedge clk);
        repeat (64) @(posedge clk);
        while (results_due.size() != 0)
        begin
            lost = results_due.pop_front();
            note_mismatch("result never arrived", 32'd0, 32'(lost.redraw_key));
        end

        $display("Covered %0d items under %0d calibration settings, from defaults to extremes.",
                 items_sent, settings_used);
        $display("Presses: %0d (%0d on a key), releases: %0d, mismatches: %0d.",
                 presses, key_hits, releases, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### files.f
hdl/tkfe_pkg.sv
hdl/tkfe_if.sv
hdl/tkfe_div.sv
hdl/tkfe_dpath.sv
hdl/tkfe_ctrl.sv
hdl/touch_key_front_end_core.sv
bench/touch_key_front_end_core_test.sv
